// ----- hw/rtl/uyvy2rgb_pkg.sv -----
// ----------------------------------------------------------------------------
// uyvy2rgb_pkg
// Shared types and constants for the packed U Y V Y Y Y to RGB888 converter.
// ----------------------------------------------------------------------------
package uyvy2rgb_pkg;

	// one byte of the packed stream
	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_start;
	} in_item_t;

	// one converted pixel
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} out_item_t;

	// luma and chroma of a pixel waiting for conversion
	typedef struct packed {
		logic [7:0] luma;
		logic [7:0] cb;
		logic [7:0] cr;
	} pix_req_t;

	// byte position inside a six-byte group
	localparam logic [2:0] PhU  = 3'd0;
	localparam logic [2:0] PhY0 = 3'd1;
	localparam logic [2:0] PhV  = 3'd2;
	localparam logic [2:0] PhY1 = 3'd3;
	localparam logic [2:0] PhY2 = 3'd4;
	localparam logic [2:0] PhY3 = 3'd5;

	// fixed point conversion, 12 fraction bits
	localparam int SumW   = 23;
	localparam int FracW  = 12;
	localparam logic signed [SumW-1:0] CoefRv    = 23'sd5743;
	localparam logic signed [SumW-1:0] CoefGu    = 23'sd1411;
	localparam logic signed [SumW-1:0] CoefGv    = 23'sd2925;
	localparam logic signed [SumW-1:0] CoefBu    = 23'sd7258;
	localparam logic signed [SumW-1:0] RoundHalf = 23'sd2048;

endpackage

// ----- hw/rtl/uyvy2rgb_unpack.sv -----
// ----------------------------------------------------------------------------
// uyvy2rgb_unpack
// Tracks the group phase, holds chroma and the first luma sample, and
// registers one pixel request per luma byte that produces output.
// ----------------------------------------------------------------------------
module uyvy2rgb_unpack (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  uyvy2rgb_pkg::in_item_t in_data,
	input  logic                   skip,
	input  logic                   s1_en,
	output logic                   pix_valid_s1,
	output uyvy2rgb_pkg::pix_req_t pix_s1
);

	logic [2:0] phase_q;
	logic [7:0] u_q;
	logic [7:0] v_q;
	logic [7:0] y0_q;
	logic [2:0] phase_cur;
	logic [2:0] phase_nxt;
	logic       emit;
	uyvy2rgb_pkg::pix_req_t req;

	// a frame start or a stray code restarts the group
	assign phase_cur = (in_data.frame_start || phase_q > uyvy2rgb_pkg::PhY3) ?
		uyvy2rgb_pkg::PhU : phase_q;
	assign phase_nxt = (phase_cur >= uyvy2rgb_pkg::PhY3) ? uyvy2rgb_pkg::PhU :
		phase_cur + 3'd1;

	always_comb begin
		emit     = 1'b0;
		req.luma = in_data.data_byte;
		req.cb   = u_q;
		req.cr   = v_q;
		case (phase_cur)
			uyvy2rgb_pkg::PhU: begin
				emit = 1'b0;
			end
			uyvy2rgb_pkg::PhY0: begin
				emit = 1'b0;
			end
			uyvy2rgb_pkg::PhV: begin
				// held y0 pairs with the v arriving now
				emit     = 1'b1;
				req.luma = y0_q;
				req.cr   = in_data.data_byte;
			end
			uyvy2rgb_pkg::PhY1: begin
				emit = 1'b1;
			end
			default: begin
				emit = !skip;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= uyvy2rgb_pkg::PhU;
			u_q     <= '0;
			v_q     <= '0;
			y0_q    <= '0;
		end else if (accept) begin
			phase_q <= phase_nxt;
			if (phase_cur == uyvy2rgb_pkg::PhU) begin
				u_q <= in_data.data_byte;
			end
			if (phase_cur == uyvy2rgb_pkg::PhY0) begin
				y0_q <= in_data.data_byte;
			end
			if (phase_cur == uyvy2rgb_pkg::PhV) begin
				v_q <= in_data.data_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_s1 <= 1'b0;
		end else if (s1_en) begin
			pix_valid_s1 <= accept && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_en && accept && emit) begin
			pix_s1 <= req;
		end
	end

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= uyvy2rgb_pkg::PhY3)
	else $error("group phase out of range");

endmodule

// ----- hw/rtl/uyvy2rgb_convert.sv -----
// ----------------------------------------------------------------------------
// uyvy2rgb_convert
// Fixed point YUV to RGB math with clamping, followed by the output register.
// ----------------------------------------------------------------------------
module uyvy2rgb_convert (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    pix_valid_s1,
	input  uyvy2rgb_pkg::pix_req_t  pix_s1,
	input  logic                    out_stall,
	output logic                    out_en,
	output logic                    out_valid,
	output uyvy2rgb_pkg::out_item_t rgb_pixel
);

	localparam int SumW  = uyvy2rgb_pkg::SumW;
	localparam int FracW = uyvy2rgb_pkg::FracW;

	logic                   valid_s2;
	uyvy2rgb_pkg::out_item_t item_s2;
	uyvy2rgb_pkg::out_item_t pix_rgb;
	logic signed [SumW-1:0] base;
	logic signed [SumW-1:0] u_ext;
	logic signed [SumW-1:0] v_ext;
	logic signed [SumW-1:0] sum_r;
	logic signed [SumW-1:0] sum_g;
	logic signed [SumW-1:0] sum_b;

	function automatic logic [7:0] clamp8(input logic signed [SumW-1:0] s);
		logic signed [SumW-1:0] q;
		q = s >>> FracW;
		if (s < 0) begin
			return 8'd0;
		end else if (q > 255) begin
			return 8'd255;
		end else begin
			return q[7:0];
		end
	endfunction

	assign base  = $signed({3'b000, pix_s1.luma, {FracW{1'b0}}}) + uyvy2rgb_pkg::RoundHalf;
	assign u_ext = $signed({{(SumW-8){pix_s1.cb[7]}}, pix_s1.cb});
	assign v_ext = $signed({{(SumW-8){pix_s1.cr[7]}}, pix_s1.cr});

	assign sum_r = base + v_ext * uyvy2rgb_pkg::CoefRv;
	assign sum_g = base - u_ext * uyvy2rgb_pkg::CoefGu - v_ext * uyvy2rgb_pkg::CoefGv;
	assign sum_b = base + u_ext * uyvy2rgb_pkg::CoefBu;

	assign pix_rgb.red   = clamp8(sum_r);
	assign pix_rgb.green = clamp8(sum_g);
	assign pix_rgb.blue  = clamp8(sum_b);

	assign out_en    = !valid_s2 || !out_stall;
	assign out_valid = valid_s2;
	assign rgb_pixel = item_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_en) begin
			valid_s2 <= pix_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_en && pix_valid_s1) begin
			item_s2 <= pix_rgb;
		end
	end

endmodule

// ----- hw/rtl/uyvyyy_to_rgb888_stream_core.sv -----
// ----------------------------------------------------------------------------
// uyvyyy_to_rgb888_stream_core
// Packed U Y V Y Y Y byte stream to RGB888 pixel converter.
// ----------------------------------------------------------------------------
// Input channel: one byte of the packed stream per item (in_valid / in_stall),
// with frame_start marking the U byte that opens a new frame; a partly
// received group is dropped. Output channel: one RGB888 pixel per luma byte
// (out_valid / out_stall); with skip mode on, the third and fourth luma of
// each group give no pixel. The Y0 pixel leaves when its V byte arrives.
// Config channel: cfg_valid / cfg_ready writes the skip-mode bit (cfg_data);
// ready is always high, write only while the stream is idle.
// Throughput: one byte per cycle while in_stall is low. Each byte is decoded
// into the request register at its accepting edge, and the color math runs
// between the request register and the result register, which drives the
// output and holds the pixel until the receiver takes it.
// Reset: group phase, chroma and held luma clear to zero, skip mode off, no
// pixels pending. When the receiver stalls, the result register holds; the
// request stage still fills, so input stalls only with both stages full.
// ----------------------------------------------------------------------------
module uyvyyy_to_rgb888_stream_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  uyvy2rgb_pkg::in_item_t  in_data,
	output logic                    out_valid,
	input  logic                    out_stall,
	output uyvy2rgb_pkg::out_item_t rgb_pixel,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic                    cfg_data
);

	logic                   skip_q;
	logic                   accept;
	logic                   s1_en;
	logic                   out_en;
	logic                   pix_valid_s1;
	uyvy2rgb_pkg::pix_req_t pix_s1;

	assign cfg_ready = 1'b1;
	assign s1_en     = !pix_valid_s1 || out_en;
	assign in_stall  = !s1_en;
	assign accept    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			skip_q <= cfg_data;
		end
	end

	uyvy2rgb_unpack u_unpack (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.in_data      (in_data),
		.skip         (skip_q),
		.s1_en        (s1_en),
		.pix_valid_s1 (pix_valid_s1),
		.pix_s1       (pix_s1)
	);

	uyvy2rgb_convert u_convert (
		.clk          (clk),
		.arst_n       (arst_n),
		.pix_valid_s1 (pix_valid_s1),
		.pix_s1       (pix_s1),
		.out_stall    (out_stall),
		.out_en       (out_en),
		.out_valid    (out_valid),
		.rgb_pixel    (rgb_pixel)
	);

	// input backs up only when both stages hold a pixel and the output is stuck
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall && pix_valid_s1))
	else $error("input stalled without a full pipeline");

	// a frame start byte is a U byte and never produces a pixel
	a_fs_no_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_data.frame_start) |=> !pix_valid_s1)
	else $error("pixel requested on frame start byte");

	// a new output pixel always comes from a pending request
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(pix_valid_s1))
	else $error("output valid without a request");

endmodule
